@@ hw/rtl/bra_pkg.sv @@
// Shared types and constants for the banker's-algorithm allocator.
// No dependencies; used by bra_lane and bankers_resource_allocator_core.
package bra_pkg;

  localparam int CUSTOMERS   = 8;
  localparam int RESOURCES   = 4;
  localparam int AMOUNT_BITS = 8;
  localparam int CIDX_BITS   = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
  localparam int WORK_BITS   = AMOUNT_BITS + $clog2(CUSTOMERS + 1);
  localparam logic [3:0] CUST_LIMIT = 4'(CUSTOMERS);
  localparam logic [CIDX_BITS-1:0] CUST_LAST = CIDX_BITS'(CUSTOMERS - 1);

  typedef logic [AMOUNT_BITS-1:0] amount_t;
  typedef logic [WORK_BITS-1:0]   work_t;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_SET     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_EXCEEDS  = 3'd1,
    ST_INSUFF   = 3'd2,
    ST_UNSAFE   = 3'd3,
    ST_RELEASED = 3'd4,
    ST_REFUSED  = 3'd5,
    ST_LOADED   = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] customer_id;
    logic [7:0] amount_0;
    logic [7:0] amount_1;
    logic [7:0] amount_2;
    logic [7:0] amount_3;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] served_customer;
    logic [7:0] avail_0;
    logic [7:0] avail_1;
    logic [7:0] avail_2;
    logic [7:0] avail_3;
  } out_item_t;

  // per-resource compare results from one lane
  typedef struct packed {
    logic need_fits_work;
    logic amt_fits_need;
    logic amt_fits_avail;
    logic amt_fits_held;
    logic held_nz;
  } lane_flags_t;

endpackage

@@ hw/rtl/bra_lane.sv @@
// One resource lane: compares and sums for a single resource type.
// Depends on bra_pkg.
module bra_lane (
  input  bra_pkg::amount_t     need_v,
  input  bra_pkg::amount_t     held_v,
  input  bra_pkg::amount_t     amt,
  input  bra_pkg::amount_t     avail,
  input  bra_pkg::work_t       work,
  output bra_pkg::work_t       work_sum,
  output bra_pkg::amount_t     avail_sat,
  output bra_pkg::lane_flags_t flags
);

  logic [bra_pkg::AMOUNT_BITS:0] avail_add;

  assign avail_add = {1'b0, avail} + {1'b0, amt};
  assign avail_sat = avail_add[bra_pkg::AMOUNT_BITS] ? '1
                   : avail_add[bra_pkg::AMOUNT_BITS-1:0];
  assign work_sum  = work + bra_pkg::WORK_BITS'(held_v);

  assign flags.need_fits_work = bra_pkg::WORK_BITS'(need_v) <= work;
  assign flags.amt_fits_need  = amt <= need_v;
  assign flags.amt_fits_avail = amt <= avail;
  assign flags.amt_fits_held  = amt <= held_v;
  assign flags.held_nz        = held_v != '0;

endmodule

@@ hw/rtl/bankers_resource_allocator_core.sv @@
// Banker's-algorithm allocator: one lane per resource type plus merge and sequencer.
// Depends on bra_pkg and bra_lane.
//
// Every transfer in gives one result out. Load, release and set-available finish
// without a safety check; a request that passes the need and available checks runs
// the safety check, which visits one customer row per cycle for CUSTOMERS passes,
// with the four resource lanes comparing need against the work vector in parallel.
// A new item is taken while a result still waits.
module bankers_resource_allocator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bra_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bra_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_CHECK, S_DONE} state_t;

  state_t state;
  bra_pkg::in_item_t item;
  bra_pkg::amount_t need_tab [bra_pkg::CUSTOMERS][bra_pkg::RESOURCES];
  bra_pkg::amount_t held_tab [bra_pkg::CUSTOMERS][bra_pkg::RESOURCES];
  bra_pkg::amount_t avail    [bra_pkg::RESOURCES];
  bra_pkg::work_t   work     [bra_pkg::RESOURCES];
  logic [bra_pkg::CUSTOMERS-1:0] finished;
  logic [bra_pkg::CIDX_BITS-1:0] cur;
  logic [bra_pkg::CIDX_BITS-1:0] pass;

  bra_pkg::amount_t    amt [bra_pkg::RESOURCES];
  bra_pkg::amount_t    rd_need [bra_pkg::RESOURCES];
  bra_pkg::amount_t    rd_held [bra_pkg::RESOURCES];
  bra_pkg::work_t      work_sum [bra_pkg::RESOURCES];
  bra_pkg::amount_t    avail_sat [bra_pkg::RESOURCES];
  bra_pkg::lane_flags_t flags [bra_pkg::RESOURCES];

  logic [bra_pkg::CIDX_BITS-1:0] cid;
  logic [bra_pkg::CIDX_BITS-1:0] row;
  logic cid_ok, out_free;
  logic fit_work, fit_need, fit_avail, fit_held, held_any;

  assign amt[0] = item.amount_0;
  assign amt[1] = item.amount_1;
  assign amt[2] = item.amount_2;
  assign amt[3] = item.amount_3;

  assign cid      = item.customer_id[bra_pkg::CIDX_BITS-1:0];
  assign cid_ok   = {1'b0, item.customer_id} < bra_pkg::CUST_LIMIT;
  assign row      = (state == S_CHECK) ? cur : cid;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  for (genvar r = 0; r < bra_pkg::RESOURCES; r++) begin : g_lane
    assign rd_need[r] = need_tab[row][r];
    assign rd_held[r] = held_tab[row][r];
    bra_lane u_lane (
      .need_v   (rd_need[r]),
      .held_v   (rd_held[r]),
      .amt      (amt[r]),
      .avail    (avail[r]),
      .work     (work[r]),
      .work_sum (work_sum[r]),
      .avail_sat(avail_sat[r]),
      .flags    (flags[r])
    );
  end

  // merge stage
  always_comb begin
    fit_work  = 1'b1;
    fit_need  = 1'b1;
    fit_avail = 1'b1;
    fit_held  = 1'b1;
    held_any  = 1'b0;
    for (int r = 0; r < bra_pkg::RESOURCES; r++) begin
      fit_work  = fit_work  & flags[r].need_fits_work;
      fit_need  = fit_need  & flags[r].amt_fits_need;
      fit_avail = fit_avail & flags[r].amt_fits_avail;
      fit_held  = fit_held  & flags[r].amt_fits_held;
      held_any  = held_any  | flags[r].held_nz;
    end
  end

  // next values of the available vector and addressed row, plus the result
  bra_pkg::amount_t avail_next [bra_pkg::RESOURCES];
  bra_pkg::amount_t need_next  [bra_pkg::RESOURCES];
  bra_pkg::amount_t held_next  [bra_pkg::RESOURCES];
  logic row_we, finish, start_check;
  bra_pkg::status_t status_next;

  always_comb begin
    row_we      = 1'b0;
    finish      = 1'b0;
    start_check = 1'b0;
    status_next = bra_pkg::ST_LOADED;
    for (int r = 0; r < bra_pkg::RESOURCES; r++) begin
      avail_next[r] = avail[r];
      need_next[r]  = rd_need[r];
      held_next[r]  = rd_held[r];
    end
    if (state == S_EXEC && out_free) begin
      case (bra_pkg::cmd_t'(item.command))
        bra_pkg::CMD_LOAD: begin
          finish = 1'b1;
          row_we = cid_ok;
          for (int r = 0; r < bra_pkg::RESOURCES; r++) begin
            need_next[r] = amt[r];
            held_next[r] = '0;
          end
        end
        bra_pkg::CMD_REQUEST: begin
          if (!cid_ok || !fit_need) begin
            finish      = 1'b1;
            status_next = bra_pkg::ST_EXCEEDS;
          end else if (!fit_avail) begin
            finish      = 1'b1;
            status_next = bra_pkg::ST_INSUFF;
          end else begin
            start_check = 1'b1;
            row_we      = 1'b1;
            for (int r = 0; r < bra_pkg::RESOURCES; r++) begin
              avail_next[r] = avail[r] - amt[r];
              need_next[r]  = rd_need[r] - amt[r];
              held_next[r]  = rd_held[r] + amt[r];
            end
          end
        end
        bra_pkg::CMD_RELEASE: begin
          finish = 1'b1;
          if (!cid_ok || !held_any || !fit_held) begin
            status_next = bra_pkg::ST_REFUSED;
          end else begin
            status_next = bra_pkg::ST_RELEASED;
            row_we      = 1'b1;
            for (int r = 0; r < bra_pkg::RESOURCES; r++) begin
              avail_next[r] = avail_sat[r];
              need_next[r]  = rd_need[r] + amt[r];
              held_next[r]  = rd_held[r] - amt[r];
            end
          end
        end
        default: begin
          finish = 1'b1;
          for (int r = 0; r < bra_pkg::RESOURCES; r++) avail_next[r] = amt[r];
        end
      endcase
    end else if (state == S_DONE && out_free) begin
      finish = 1'b1;
      if (&finished) begin
        status_next = bra_pkg::ST_GRANTED;
      end else begin
        // roll back the tentative grant; no saturation since it came from a subtract
        status_next = bra_pkg::ST_UNSAFE;
        row_we      = 1'b1;
        for (int r = 0; r < bra_pkg::RESOURCES; r++) begin
          avail_next[r] = avail_sat[r];
          need_next[r]  = rd_need[r] + amt[r];
          held_next[r]  = rd_held[r] - amt[r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      finished  <= '0;
      cur       <= '0;
      pass      <= '0;
      for (int r = 0; r < bra_pkg::RESOURCES; r++) begin
        avail[r] <= '0;
        work[r]  <= '0;
      end
      for (int c = 0; c < bra_pkg::CUSTOMERS; c++) begin
        for (int r = 0; r < bra_pkg::RESOURCES; r++) begin
          need_tab[c][r] <= '0;
          held_tab[c][r] <= '0;
        end
      end
    end else begin
      for (int r = 0; r < bra_pkg::RESOURCES; r++) avail[r] <= avail_next[r];
      if (row_we) begin
        for (int r = 0; r < bra_pkg::RESOURCES; r++) begin
          need_tab[cid][r] <= need_next[r];
          held_tab[cid][r] <= held_next[r];
        end
      end
      if (finish) begin
        out_valid                <= 1'b1;
        out_data.status          <= status_next;
        out_data.served_customer <= item.customer_id;
        out_data.avail_0         <= avail_next[0];
        out_data.avail_1         <= avail_next[1];
        out_data.avail_2         <= avail_next[2];
        out_data.avail_3         <= avail_next[3];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (start_check) begin
            finished <= '0;
            cur      <= '0;
            pass     <= '0;
            for (int r = 0; r < bra_pkg::RESOURCES; r++) begin
              work[r] <= bra_pkg::WORK_BITS'(avail_next[r]);
            end
            state <= S_CHECK;
          end else if (finish) begin
            state <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (!finished[cur] && fit_work) begin
            finished[cur] <= 1'b1;
            for (int r = 0; r < bra_pkg::RESOURCES; r++) work[r] <= work_sum[r];
          end
          if (cur == bra_pkg::CUST_LAST) begin
            cur  <= '0;
            pass <= pass + 1'b1;
            if (pass == bra_pkg::CUST_LAST) state <= S_DONE;
          end else begin
            cur <= cur + 1'b1;
          end
        end
        S_DONE: begin
          if (finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // granted and unsafe only come out of the safety check
  a_check_status: assert property (@(posedge clk) disable iff (rst)
    finish && (status_next == bra_pkg::ST_GRANTED || status_next == bra_pkg::ST_UNSAFE)
    |-> state == S_DONE)
    else $error("grant/unsafe outside safety check");

  // finished marks only accumulate during a check
  a_marks_grow: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK && $past(state) == S_CHECK |-> (finished & $past(finished)) == $past(finished))
    else $error("finished mark cleared during check");

  // available amount of resource 0 held during the check
  a_avail_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK && $past(state) == S_CHECK |-> avail[0] == $past(avail[0]))
    else $error("available changed during check");

  // no status code beyond loaded
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= bra_pkg::ST_LOADED)
    else $error("bad status code");

endmodule
